FILE: hw/rtl/prq_pkg.sv
// Package for the priority run queue: field widths, opcodes, status codes
// and the sequencer state type. No dependencies.
package prq_pkg;

  localparam int OPCODE_W = 2;
  localparam int ID_W     = 6;
  localparam int LEVEL_W  = 4;
  localparam int COUNT_W  = 7;
  localparam int HINT_W   = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_HOLD = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_NONE = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_EQ_LINK,
    S_EQ_TAIL,
    S_HOLD_WR,
    S_DQ_SCAN,
    S_DQ_HEAD,
    S_DQ_HWORD,
    S_DQ_WALK,
    S_DQ_CUR,
    S_OUT
  } state_t;

endpackage

FILE: hw/rtl/prq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (read-first). No dependencies.
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/prq_scan.sv
// Level scanner: finds the most urgent non-empty level at or after a start
// level. Pure priority encoder, no dependencies.
module prq_scan #(
  parameter int LEVELS = 16
) (
  input  logic [LEVELS-1:0]           nonempty,
  input  logic [$clog2(LEVELS+1)-1:0] start,
  output logic                        found,
  output logic [$clog2(LEVELS)-1:0]   level
);

  localparam int SW = $clog2(LEVELS + 1);
  localparam int LW = $clog2(LEVELS);

  always_comb begin
    found = 1'b0;
    level = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i] && (SW'(i) >= start)) begin
        found = 1'b1;
        level = LW'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/priority_run_queue.sv
// Top level of the priority run queue: sequencer, level and task memories.
// Depends on prq_pkg, prq_ram and prq_scan.
//
//   channel | direction | beat carries
//   in_     | input     | opcode, task_id, task_level, hold_value
//   out_    | output    | status, granted_id, granted_level, ready_count, ready_hint
//
// Enqueue: idle, link, tail when its level holds another task, then output, where
// the output register is loaded. Hold: idle, hold write, output. No-op or rejected
// beat: idle, output. Dequeue: scan for a level, read its head, then its task word,
// walk past held tasks one task read at a time; a level with no free task is skipped;
// output follows a grant or an empty scan. After reset a clearing pass writes every
// task entry before the first beat is taken. A new beat is taken while a result
// waits; a stalled output holds the sequencer in its final state.
module priority_run_queue #(
  parameter int LEVELS = 16,
  parameter int TASKS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [prq_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [prq_pkg::ID_W-1:0]      in_task_id,
  input  logic [prq_pkg::LEVEL_W-1:0]   in_task_level,
  input  logic                          in_hold_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [prq_pkg::ID_W-1:0]      out_granted_id,
  output logic [prq_pkg::LEVEL_W-1:0]   out_granted_level,
  output logic [prq_pkg::COUNT_W-1:0]   out_ready_count,
  output logic [prq_pkg::HINT_W-1:0]    out_ready_hint
);

  import prq_pkg::*;

  localparam int TW     = $clog2(TASKS);
  localparam int LW     = $clog2(LEVELS);
  localparam int HW     = $clog2(LEVELS + 1);
  localparam int STW    = $clog2(TASKS + 1);
  localparam int WW     = TW + 2;
  localparam int LWW    = 2 * TW;
  localparam int HOLD_B = TW + 1;
  localparam int LINK_B = TW;

  state_t state_r, state_nxt;
  logic [TW-1:0]      id_r, id_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic               hv_r, hv_nxt;
  logic [TW-1:0]      clr_r, clr_nxt;
  logic [HW-1:0]      scan_r, scan_nxt;
  logic [LW-1:0]      cur_lvl_r, cur_lvl_nxt;
  logic [TW-1:0]      head_r, head_nxt;
  logic [TW-1:0]      prev_r, prev_nxt;
  logic [WW-1:0]      prev_word_r, prev_word_nxt;
  logic [TW-1:0]      cur_r, cur_nxt;
  logic [STW-1:0]     steps_r, steps_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [HW-1:0]      hint_r, hint_nxt;
  logic [LEVELS-1:0]  nonempty_r, nonempty_nxt;
  logic               res_status_r, res_status_nxt;
  logic [TW-1:0]      res_gid_r, res_gid_nxt;
  logic [LW-1:0]      res_glvl_r, res_glvl_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [ID_W-1:0]    out_gid_r, out_gid_nxt;
  logic [LEVEL_W-1:0] out_glvl_r, out_glvl_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [HINT_W-1:0]  out_hint_r, out_hint_nxt;

  logic           t_we, t_re;
  logic [TW-1:0]  t_waddr, t_raddr;
  logic [WW-1:0]  t_wdata, t_rdata;
  logic           l_we, l_re;
  logic [LW-1:0]  l_waddr, l_raddr;
  logic [LWW-1:0] l_wdata, l_rdata;

  logic          scan_found;
  logic [LW-1:0] scan_level;
  logic          id_ok, lvl_ok, out_free, eq_link_tail, walk_go;
  logic [TW-1:0] l_head, l_tail;

  prq_ram #(.WIDTH(WW), .DEPTH(TASKS)) u_task_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  prq_ram #(.WIDTH(LWW), .DEPTH(LEVELS)) u_level_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  prq_scan #(.LEVELS(LEVELS)) u_scan (
    .nonempty (nonempty_r),
    .start    (scan_r),
    .found    (scan_found),
    .level    (scan_level)
  );

  assign id_ok        = int'(in_task_id) < TASKS;
  assign lvl_ok       = int'(in_task_level) < LEVELS;
  assign out_free     = !out_valid_r || out_ready;
  assign l_head       = l_rdata[LWW-1:TW];
  assign l_tail       = l_rdata[TW-1:0];
  assign eq_link_tail = nonempty_r[lvl_r] && (l_tail != id_r);
  assign walk_go      = (steps_r < STW'(TASKS)) && prev_word_r[LINK_B];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_r == TW'(TASKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_opcode))
            OP_ENQ:  state_nxt = (id_ok && lvl_ok) ? S_EQ_LINK : S_OUT;
            OP_DEQ:  state_nxt = S_DQ_SCAN;
            OP_HOLD: state_nxt = id_ok ? S_HOLD_WR : S_OUT;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_EQ_LINK:  state_nxt = eq_link_tail ? S_EQ_TAIL : S_OUT;
      S_EQ_TAIL:  state_nxt = S_OUT;
      S_HOLD_WR:  state_nxt = S_OUT;
      S_DQ_SCAN:  state_nxt = scan_found ? S_DQ_HEAD : S_OUT;
      S_DQ_HEAD:  state_nxt = S_DQ_HWORD;
      S_DQ_HWORD: state_nxt = t_rdata[HOLD_B] ? S_DQ_WALK : S_OUT;
      S_DQ_WALK:  state_nxt = walk_go ? S_DQ_CUR : S_DQ_SCAN;
      S_DQ_CUR:   state_nxt = t_rdata[HOLD_B] ? S_DQ_WALK : S_OUT;
      S_OUT:      state_nxt = out_free ? S_IDLE : S_OUT;
      default:    state_nxt = S_CLR;
    endcase
  end

  // Memory controls and register updates.
  always_comb begin
    in_ready       = 1'b0;
    t_we           = 1'b0;
    t_re           = 1'b0;
    t_waddr        = '0;
    t_raddr        = '0;
    t_wdata        = '0;
    l_we           = 1'b0;
    l_re           = 1'b0;
    l_waddr        = '0;
    l_raddr        = '0;
    l_wdata        = '0;
    id_nxt         = id_r;
    lvl_nxt        = lvl_r;
    hv_nxt         = hv_r;
    clr_nxt        = clr_r;
    scan_nxt       = scan_r;
    cur_lvl_nxt    = cur_lvl_r;
    head_nxt       = head_r;
    prev_nxt       = prev_r;
    prev_word_nxt  = prev_word_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    count_nxt      = count_r;
    hint_nxt       = hint_r;
    nonempty_nxt   = nonempty_r;
    res_status_nxt = res_status_r;
    res_gid_nxt    = res_gid_r;
    res_glvl_nxt   = res_glvl_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_gid_nxt    = out_gid_r;
    out_glvl_nxt   = out_glvl_r;
    out_count_nxt  = out_count_r;
    out_hint_nxt   = out_hint_r;

    unique case (state_r)
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          id_nxt       = TW'(in_task_id);
          lvl_nxt      = LW'(in_task_level);
          hv_nxt       = in_hold_value;
          scan_nxt     = '0;
          res_gid_nxt  = '0;
          res_glvl_nxt = '0;
          t_re         = 1'b1;
          t_raddr      = TW'(in_task_id);
          l_re         = 1'b1;
          l_raddr      = LW'(in_task_level);
          res_status_nxt = ST_OK;
          if ((op_t'(in_opcode) == OP_ENQ && !(id_ok && lvl_ok)) ||
              (op_t'(in_opcode) == OP_HOLD && !id_ok)) begin
            res_status_nxt = ST_NONE;
          end
        end
      end
      S_EQ_LINK: begin
        t_we    = 1'b1;
        t_waddr = id_r;
        t_wdata = {t_rdata[HOLD_B], 1'b0, TW'(0)};
        l_we    = 1'b1;
        l_waddr = lvl_r;
        l_wdata = {(nonempty_r[lvl_r] ? l_head : id_r), id_r};
        nonempty_nxt[lvl_r] = 1'b1;
        if (HW'(lvl_r) < hint_r) begin
          hint_nxt = HW'(lvl_r);
        end
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
        if (eq_link_tail) begin
          t_re     = 1'b1;
          t_raddr  = l_tail;
          prev_nxt = l_tail;
        end
      end
      S_EQ_TAIL: begin
        t_we    = 1'b1;
        t_waddr = prev_r;
        t_wdata = {t_rdata[HOLD_B], 1'b1, id_r};
      end
      S_HOLD_WR: begin
        t_we    = 1'b1;
        t_waddr = id_r;
        t_wdata = {hv_r, t_rdata[LINK_B:0]};
      end
      S_DQ_SCAN: begin
        if (scan_found) begin
          cur_lvl_nxt = scan_level;
          l_re        = 1'b1;
          l_raddr     = scan_level;
        end else begin
          hint_nxt       = HW'(LEVELS);
          res_status_nxt = ST_NONE;
          res_gid_nxt    = '0;
          res_glvl_nxt   = '0;
        end
      end
      S_DQ_HEAD: begin
        head_nxt = l_head;
        t_re     = 1'b1;
        t_raddr  = l_head;
      end
      S_DQ_HWORD: begin
        if (!t_rdata[HOLD_B]) begin
          if (t_rdata[LINK_B]) begin
            l_we     = 1'b1;
            l_waddr  = cur_lvl_r;
            l_wdata  = {t_rdata[TW-1:0], l_tail};
            hint_nxt = HW'(cur_lvl_r);
          end else begin
            nonempty_nxt[cur_lvl_r] = 1'b0;
            hint_nxt = HW'(cur_lvl_r) + HW'(1);
          end
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          res_status_nxt = ST_OK;
          res_gid_nxt    = head_r;
          res_glvl_nxt   = cur_lvl_r;
        end else begin
          prev_nxt      = head_r;
          prev_word_nxt = t_rdata;
          steps_nxt     = '0;
        end
      end
      S_DQ_WALK: begin
        if (walk_go) begin
          t_re    = 1'b1;
          t_raddr = prev_word_r[TW-1:0];
          cur_nxt = prev_word_r[TW-1:0];
        end else begin
          scan_nxt = HW'(cur_lvl_r) + HW'(1);
        end
      end
      S_DQ_CUR: begin
        if (t_rdata[HOLD_B]) begin
          prev_nxt      = cur_r;
          prev_word_nxt = t_rdata;
          steps_nxt     = steps_r + 1'b1;
        end else begin
          t_we     = 1'b1;
          t_waddr  = prev_r;
          t_wdata  = {prev_word_r[HOLD_B], t_rdata[LINK_B:0]};
          hint_nxt = HW'(cur_lvl_r);
          if (!t_rdata[LINK_B]) begin
            hint_nxt = HW'(cur_lvl_r) + HW'(1);
            l_we     = 1'b1;
            l_waddr  = cur_lvl_r;
            l_wdata  = {head_r, prev_r};
          end
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          res_status_nxt = ST_OK;
          res_gid_nxt    = cur_r;
          res_glvl_nxt   = cur_lvl_r;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_gid_nxt    = ID_W'(res_gid_r);
          out_glvl_nxt   = LEVEL_W'(res_glvl_r);
          out_count_nxt  = count_r;
          out_hint_nxt   = HINT_W'(hint_r);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      count_r     <= '0;
      hint_r      <= HW'(LEVELS);
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      hint_r      <= hint_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    lvl_r        <= lvl_nxt;
    hv_r         <= hv_nxt;
    scan_r       <= scan_nxt;
    cur_lvl_r    <= cur_lvl_nxt;
    head_r       <= head_nxt;
    prev_r       <= prev_nxt;
    prev_word_r  <= prev_word_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_gid_r    <= res_gid_nxt;
    res_glvl_r   <= res_glvl_nxt;
    out_status_r <= out_status_nxt;
    out_gid_r    <= out_gid_nxt;
    out_glvl_r   <= out_glvl_nxt;
    out_count_r  <= out_count_nxt;
    out_hint_r   <= out_hint_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_id    = out_gid_r;
  assign out_granted_level = out_glvl_r;
  assign out_ready_count   = out_count_r;
  assign out_ready_hint    = out_hint_r;

  // The sequencer never reads a task entry in the cycle it writes it.
  a_no_task_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(t_we && t_re && (t_waddr == t_raddr)))
    else $error("task memory read and write hit the same entry");

  // An accepted beat always moves the sequencer out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted beat left the sequencer idle");

  // A new result is loaded only from the output state.
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside the output state");

  // A finished result waits while the output register is stalled.
  a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> (state_r == S_OUT))
    else $error("finished result dropped during an output stall");

endmodule

FILE: verif/prq_run_checker.sv
`timescale 1ns / 100ps
// Checker for the priority run queue: watches both channels, predicts each result beat
// from the accepted input beats and compares them in order. Depends on prq_pkg.
module prq_run_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [prq_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [prq_pkg::ID_W-1:0]      in_task_id,
  input  logic [prq_pkg::LEVEL_W-1:0]   in_task_level,
  input  logic                          in_hold_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_status,
  input  logic [prq_pkg::ID_W-1:0]      out_granted_id,
  input  logic [prq_pkg::LEVEL_W-1:0]   out_granted_level,
  input  logic [prq_pkg::COUNT_W-1:0]   out_ready_count,
  input  logic [prq_pkg::HINT_W-1:0]    out_ready_hint,
  output int                            fail_count,
  output int                            outstanding
);
  import prq_pkg::*;

  localparam int LEVELS       = 16;
  localparam int TASKS        = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic               status;
    logic [ID_W-1:0]    granted_id;
    logic [LEVEL_W-1:0] granted_level;
    logic [COUNT_W-1:0] ready_count;
    logic [HINT_W-1:0]  ready_hint;
  } run_result_t;

  logic [ID_W-1:0]    lvl_first [LEVELS];
  logic [ID_W-1:0]    lvl_last  [LEVELS];
  logic [LEVELS-1:0]  lvl_busy;
  logic [ID_W-1:0]    succ      [TASKS];
  logic [TASKS-1:0]   succ_ok;
  logic [TASKS-1:0]   held;
  logic [COUNT_W-1:0] queued;
  logic [HINT_W-1:0]  best_hint;

  run_result_t due_results[$];

  function automatic run_result_t schedule_step(op_t op, logic [ID_W-1:0] id,
                                                logic [LEVEL_W-1:0] lvl, logic hv);
    run_result_t r;
    logic [ID_W-1:0] h;
    logic [ID_W-1:0] prev;
    logic [ID_W-1:0] cur;
    logic granted;
    r = '0;
    granted = 1'b0;
    case (op)
      OP_ENQ: begin
        if (lvl_busy[lvl]) begin
          succ[lvl_last[lvl]] = id;
          succ_ok[lvl_last[lvl]] = 1'b1;
        end else begin
          lvl_first[lvl] = id;
          lvl_busy[lvl] = 1'b1;
        end
        lvl_last[lvl] = id;
        succ_ok[id] = 1'b0;
        if (HINT_W'(lvl) < best_hint) best_hint = HINT_W'(lvl);
        if (queued != COUNT_MAX) queued = queued + 1'b1;
      end
      OP_DEQ: begin
        best_hint = HINT_W'(LEVELS);
        for (int lv = 0; lv < LEVELS && !granted; lv++) begin
          if (lvl_busy[lv]) begin
            h = lvl_first[lv];
            if (!held[h]) begin
              if (succ_ok[h]) begin
                lvl_first[lv] = succ[h];
                best_hint = HINT_W'(lv);
              end else begin
                lvl_busy[lv] = 1'b0;
                lvl_first[lv] = '0;
                lvl_last[lv] = '0;
                best_hint = HINT_W'(lv + 1);
              end
              r.granted_id = h;
              r.granted_level = LEVEL_W'(lv);
              granted = 1'b1;
            end else begin
              // The head is held, so walk the list for the first task that is not.
              prev = h;
              for (int s = 0; s < TASKS && succ_ok[prev] && !granted; s++) begin
                cur = succ[prev];
                if (held[cur]) begin
                  prev = cur;
                end else begin
                  succ[prev] = succ[cur];
                  succ_ok[prev] = succ_ok[cur];
                  best_hint = HINT_W'(lv);
                  if (!succ_ok[cur]) begin
                    best_hint = HINT_W'(lv + 1);
                    lvl_last[lv] = prev;
                  end
                  r.granted_id = cur;
                  r.granted_level = LEVEL_W'(lv);
                  granted = 1'b1;
                end
              end
            end
          end
        end
        if (granted) begin
          if (queued != '0) queued = queued - 1'b1;
        end else begin
          r.status = ST_NONE;
        end
      end
      OP_HOLD: begin
        held[id] = hv;
      end
      default: begin
      end
    endcase
    r.ready_count = queued;
    r.ready_hint = best_hint;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    run_result_t seen;
    run_result_t want;
    if (!rst_n) begin
      for (int lv = 0; lv < LEVELS; lv++) begin
        lvl_first[lv] = '0;
        lvl_last[lv] = '0;
      end
      for (int t = 0; t < TASKS; t++) succ[t] = '0;
      lvl_busy = '0;
      succ_ok = '0;
      held = '0;
      queued = '0;
      best_hint = HINT_W'(LEVELS);
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = '{status: out_status, granted_id: out_granted_id,
                 granted_level: out_granted_level, ready_count: out_ready_count,
                 ready_hint: out_ready_hint};
        if (due_results.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("%0t: result beat with nothing expected: status %0d id %0d level %0d",
                     $realtime, seen.status, seen.granted_id, seen.granted_level);
          end
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (seen !== want) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("%0t: result mismatch (expected/actual): status %0d/%0d id %0d/%0d",
                       $realtime, want.status, seen.status, want.granted_id,
                       seen.granted_id);
              $display("  level %0d/%0d count %0d/%0d hint %0d/%0d",
                       want.granted_level, seen.granted_level, want.ready_count,
                       seen.ready_count, want.ready_hint, seen.ready_hint);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        due_results.push_back(schedule_step(op_t'(in_opcode), in_task_id, in_task_level,
                                            in_hold_value));
      end
    end
    outstanding <= due_results.size();
  end

endmodule

FILE: verif/tb_priority_run_queue.sv
`timescale 1ns / 100ps
// Top of the priority run queue testbench: clock, reset, stimulus and the verdict.
// Depends on prq_pkg, the priority_run_queue RTL and prq_run_checker.
module tb_priority_run_queue;
  import prq_pkg::*;

  localparam int LONG_HOLD = 400;

  typedef struct {
    int beats;
    int enq_pct;
    int deq_pct;
    int hold_pct;
    bit any_id;
    bit steady;
    bit long_hold;
  } phase_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OPCODE_W-1:0] in_opcode;
  logic [ID_W-1:0]     in_task_id;
  logic [LEVEL_W-1:0]  in_task_level;
  logic                in_hold_value;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_status;
  logic [ID_W-1:0]     out_granted_id;
  logic [LEVEL_W-1:0]  out_granted_level;
  logic [COUNT_W-1:0]  out_ready_count;
  logic [HINT_W-1:0]   out_ready_hint;

  int          fail_count;
  int          outstanding;
  logic        steady = 1'b0;
  int          long_hold_req = 0;
  int          long_hold_seen = 0;
  int          stall_left = 0;
  logic [63:0] queued_ids = '0;
  logic [63:0] held_ids = '0;
  op_t         op_log[$];

  always #1 clk = ~clk;

  priority_run_queue uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_task_id       (in_task_id),
    .in_task_level    (in_task_level),
    .in_hold_value    (in_hold_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_id   (out_granted_id),
    .out_granted_level(out_granted_level),
    .out_ready_count  (out_ready_count),
    .out_ready_hint   (out_ready_hint)
  );

  prq_run_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_task_id       (in_task_id),
    .in_task_level    (in_task_level),
    .in_hold_value    (in_hold_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_id   (out_granted_id),
    .out_granted_level(out_granted_level),
    .out_ready_count  (out_ready_count),
    .out_ready_hint   (out_ready_hint),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin : rx_pacing
    int roll;
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (long_hold_req != long_hold_seen) begin
      // Long hold-off so that the block fills up and stalls its input.
      long_hold_seen <= long_hold_req;
      out_ready <= 1'b0;
      stall_left <= LONG_HOLD - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      out_ready <= (roll >= 25);
      if (roll < 3) stall_left <= $urandom_range(10, 40);
    end
  end

  // Rough view of which tasks are queued or held, used only to steer stimulus.
  always @(posedge clk) begin : id_tracking
    logic [63:0] q_next;
    logic [63:0] h_next;
    op_t op;
    q_next = queued_ids;
    h_next = held_ids;
    if (rst_n && out_valid && out_ready && op_log.size() != 0) begin
      op = op_log.pop_front();
      if (op == OP_DEQ) begin
        if (out_status == ST_OK) q_next[out_granted_id] = 1'b0;
        else if (held_ids == '0) q_next = '0;
      end
    end
    if (rst_n && in_valid && in_ready) begin
      op_log.push_back(op_t'(in_opcode));
      if (op_t'(in_opcode) == OP_ENQ) q_next[in_task_id] = 1'b1;
      if (op_t'(in_opcode) == OP_HOLD) h_next[in_task_id] = in_hold_value;
    end
    queued_ids <= q_next;
    held_ids <= h_next;
  end

  task automatic offer(input op_t op, input logic [ID_W-1:0] id,
                       input logic [LEVEL_W-1:0] lvl, input logic hv);
    int gap;
    int roll;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_task_id <= id;
    in_task_level <= lvl;
    in_hold_value <= hv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = 0;
    if (!steady) begin
      roll = $urandom_range(0, 99);
      if (roll >= 93) gap = $urandom_range(8, 40);
      else if (roll >= 65) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] free_task_id(bit any_id);
    logic [ID_W-1:0] id;
    id = ID_W'($urandom_range(0, 63));
    if (any_id || queued_ids == '1 || $urandom_range(0, 99) < 15) return id;
    for (int n = 0; n < 64; n++) begin
      if (!queued_ids[id]) return id;
      id = id + 1'b1;
    end
    return id;
  endfunction

  function automatic logic [ID_W-1:0] queued_task_id();
    logic [ID_W-1:0] id;
    id = ID_W'($urandom_range(0, 63));
    if (queued_ids == '0 || $urandom_range(0, 99) < 30) return id;
    for (int n = 0; n < 64; n++) begin
      if (queued_ids[id]) return id;
      id = id + 1'b1;
    end
    return id;
  endfunction

  initial begin : stimulus
    phase_t plan[9];
    int roll;
    logic [LEVEL_W-1:0] lvl;
    logic hv;
    plan = '{'{250, 45, 40, 10, 1'b0, 1'b0, 1'b0},
             '{150, 75, 15,  5, 1'b0, 1'b0, 1'b0},
             '{250, 45, 45,  5, 1'b0, 1'b0, 1'b1},
             '{250, 35, 35, 25, 1'b0, 1'b0, 1'b0},
             '{180, 95,  0,  0, 1'b1, 1'b0, 1'b0},
             '{200,  5, 85,  5, 1'b0, 1'b0, 1'b0},
             '{200, 25, 25, 25, 1'b1, 1'b0, 1'b0},
             '{250, 40, 40, 15, 1'b0, 1'b1, 1'b0},
             '{150, 10, 75, 15, 1'b0, 1'b0, 1'b0}};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_NOP;
    in_task_id <= '0;
    in_task_level <= '0;
    in_hold_value <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    offer(OP_DEQ, 6'd0, 4'd0, 1'b0);
    offer(OP_NOP, 6'd63, 4'd15, 1'b1);
    offer(OP_ENQ, 6'd0, 4'd15, 1'b0);
    offer(OP_ENQ, 6'd63, 4'd0, 1'b1);
    offer(OP_ENQ, 6'd5, 4'd0, 1'b0);
    offer(OP_ENQ, 6'd9, 4'd0, 1'b0);
    offer(OP_HOLD, 6'd63, 4'd0, 1'b1);
    offer(OP_HOLD, 6'd5, 4'd0, 1'b1);
    // The walk passes both held tasks and takes the tail of level 0.
    offer(OP_DEQ, 6'd63, 4'd15, 1'b1);
    offer(OP_DEQ, 6'd0, 4'd0, 1'b0);
    offer(OP_DEQ, 6'd0, 4'd0, 1'b0);
    offer(OP_HOLD, 6'd63, 4'd15, 1'b0);
    offer(OP_DEQ, 6'd0, 4'd0, 1'b0);
    offer(OP_HOLD, 6'd5, 4'd0, 1'b0);
    offer(OP_ENQ, 6'd7, 4'd3, 1'b0);
    offer(OP_ENQ, 6'd8, 4'd3, 1'b0);
    offer(OP_ENQ, 6'd7, 4'd3, 1'b0);
    offer(OP_ENQ, 6'd7, 4'd4, 1'b0);
    offer(OP_DEQ, 6'd0, 4'd0, 1'b0);
    offer(OP_DEQ, 6'd0, 4'd0, 1'b0);
    offer(OP_DEQ, 6'd0, 4'd0, 1'b0);
    offer(OP_DEQ, 6'd0, 4'd0, 1'b0);
    offer(OP_DEQ, 6'd0, 4'd0, 1'b0);
    drain_wait();

    foreach (plan[p]) begin
      steady <= plan[p].steady;
      if (plan[p].long_hold) long_hold_req <= long_hold_req + 1;
      for (int n = 0; n < plan[p].beats; n++) begin
        roll = $urandom_range(0, 99);
        hv = ($countones(held_ids) > 6) ? 1'b0 : ($urandom_range(0, 99) < 40);
        if (roll < plan[p].enq_pct) begin
          lvl = ($urandom_range(0, 9) < 6) ? LEVEL_W'($urandom_range(0, 3))
                                           : LEVEL_W'($urandom_range(0, 15));
          offer(OP_ENQ, free_task_id(plan[p].any_id), lvl, 1'($urandom_range(0, 1)));
        end else if (roll < plan[p].enq_pct + plan[p].deq_pct) begin
          offer(OP_DEQ, ID_W'($urandom_range(0, 63)), LEVEL_W'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)));
        end else if (roll < plan[p].enq_pct + plan[p].deq_pct + plan[p].hold_pct) begin
          offer(OP_HOLD, plan[p].any_id ? ID_W'($urandom_range(0, 63)) : queued_task_id(),
                LEVEL_W'($urandom_range(0, 15)), hv);
        end else begin
          offer(OP_NOP, ID_W'($urandom_range(0, 63)), LEVEL_W'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)));
        end
      end
      drain_wait();
    end

    repeat (300) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
